>>> hw/rtl/rcts_pkg.sv
package rcts_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd0;
    localparam logic [2:0] CFG_CEILING_COLOR = 3'd1;
    localparam logic [2:0] CFG_FLOOR_COLOR   = 3'd2;
    localparam logic [2:0] CFG_VIEW_PITCH    = 3'd3;
    localparam logic [2:0] CFG_EYE_OFFSET    = 3'd4;
    localparam logic [2:0] CFG_PLAYER_X      = 3'd5;
    localparam logic [2:0] CFG_PLAYER_Y      = 3'd6;

    localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd480;

    // Item actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_SHADE = 1'b1;

    // Hit sides
    localparam logic SIDE_VERTICAL = 1'b0;

    // Texture faces
    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_WEST  = 2'd2;
    localparam logic [1:0] FACE_EAST  = 2'd3;

    // Pixel regions
    typedef logic [1:0] t_region;
    localparam t_region REGION_CEILING = 2'd0;
    localparam t_region REGION_WALL    = 2'd1;
    localparam t_region REGION_FLOOR   = 2'd2;

endpackage

>>> hw/rtl/raycast_column_texel_shader.sv
// Textured wall column shader for a raycast renderer.
// Input channel (i_in_valid / o_in_ready) takes one item per cycle unless
// the output stalls. A load item (action 0) writes one texel of one of four
// faces into the texture store and gives no result. A shade item (action 1)
// gives one pixel on the output channel (o_out_valid / i_out_ready): ceiling
// colour, a texel of the selected face, or floor colour, with its region
// code. Shade items whose row is at or past screen_height - 1 give no result.
// Throughput: one item per cycle while i_out_ready stays high. Each item
// passes stages 1 to 4, one divider stage per texture row bit, the address
// stage, the registered texture store read and the output register before
// it reaches o_out_valid.
// Configuration: plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_data);
// write only while no item is in flight. Indexes beyond the list are ignored.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores the
// register defaults; the texture store keeps its contents and holds
// undefined values until loaded.
// Stall: when i_out_ready is low the result holds at the output and the
// stages behind it keep filling bubbles; input is refused only once every
// stage holds an item.
module raycast_column_texel_shader
    import rcts_pkg::*;
#(
    parameter int TEX_WIDTH  = 64,
    parameter int TEX_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [1:0]  i_load_face,
    input  logic [11:0] i_load_address,
    input  logic [31:0] i_load_color,
    input  logic [9:0]  i_pixel_row,
    input  logic [10:0] i_column,
    input  logic        i_hit_side,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic [31:0] i_hit_distance,
    input  logic [15:0] i_wall_span,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [10:0] o_out_column,
    output logic [9:0]  o_out_row,
    output logic [31:0] o_out_color,
    output logic [1:0]  o_region
);

    localparam int CW  = $clog2(TEX_WIDTH);   // texture column bits
    localparam int QW  = $clog2(TEX_HEIGHT);  // texture row bits
    localparam int BW  = 36;                  // span arithmetic at scale 2^19
    localparam int UW  = 18;                  // screen row of span edges
    localparam int DW  = UW - 1;              // span length and row offset
    localparam int NW  = DW + QW;             // dividend
    localparam int PW  = 39;                  // fraction times width
    localparam int AW  = 20;                  // texel address before wrap
    localparam logic signed [BW-1:0] TRUNC_BIAS = BW'(524287);

    // ---------------- configuration registers ----------------
    logic [10:0]        r_screen_height;
    logic [31:0]        r_ceiling_color;
    logic [31:0]        r_floor_color;
    logic signed [14:0] r_view_pitch;
    logic signed [14:0] r_eye_offset;
    logic [23:0]        r_player_x;
    logic [23:0]        r_player_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= SCREEN_HEIGHT_RESET;
            r_ceiling_color <= '0;
            r_floor_color   <= '0;
            r_view_pitch    <= '0;
            r_eye_offset    <= '0;
            r_player_x      <= '0;
            r_player_y      <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[10:0];
                CFG_CEILING_COLOR: r_ceiling_color <= i_cfg_data;
                CFG_FLOOR_COLOR:   r_floor_color   <= i_cfg_data;
                CFG_VIEW_PITCH:    r_view_pitch    <= i_cfg_data[14:0];
                CFG_EYE_OFFSET:    r_eye_offset    <= i_cfg_data[14:0];
                CFG_PLAYER_X:      r_player_x      <= i_cfg_data[23:0];
                CFG_PLAYER_Y:      r_player_y      <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Height minus one, signed so that heights of 0 and 1 drop every row
    logic signed [11:0] w_hm1;
    assign w_hm1 = $signed({1'b0, r_screen_height}) - 12'sd1;

    // ---------------- stall chain ----------------
    logic r1_v, r2_v, r3_v, r4_v, ra_v, rm_v, ro_v;
    logic w_en1, w_en2, w_en3, w_en4, w_ena, w_enm, w_eno;
    logic w_div_ready, w_div_valid;

    assign w_eno = !ro_v || i_out_ready;
    assign w_enm = !rm_v || w_eno;
    assign w_ena = !ra_v || w_enm;
    assign w_en4 = !r4_v || w_div_ready;
    assign w_en3 = !r3_v || w_en4;
    assign w_en2 = !r2_v || w_en3;
    assign w_en1 = !r1_v || w_en2;
    assign o_in_ready = w_en1;

    // Fields that stages 1 to 4 and the divider carry along
    typedef struct packed {
        logic        act;
        logic [1:0]  lface;
        logic [11:0] laddr;
        logic [31:0] lcolor;
        logic [9:0]  row;
        logic [10:0] col;
        logic [1:0]  face;
    } t_carry;

    // ---------------- stage 1: face, products ----------------
    t_carry             r1_c;
    logic               r1_side;
    logic signed [26:0] r1_pp;
    logic signed [31:0] r1_we;
    logic [29:0]        r1_hp;
    logic [15:0]        r1_ws;
    logic               w_keep;
    logic [1:0]         w_face;
    logic signed [48:0] w_hprod;

    // Drop shade rows at or past height minus one right here
    assign w_keep = (i_action == ACT_LOAD) ||
                    ($signed({2'b00, i_pixel_row}) < w_hm1);

    always_comb begin
        if (i_hit_side == SIDE_VERTICAL) begin
            w_face  = (!i_dir_x[15] && i_dir_x != '0) ? FACE_EAST : FACE_WEST;
            w_hprod = 49'($signed({1'b0, i_hit_distance})) * 49'(i_dir_y);
        end else begin
            w_face  = (!i_dir_y[15] && i_dir_y != '0) ? FACE_SOUTH : FACE_NORTH;
            w_hprod = 49'($signed({1'b0, i_hit_distance})) * 49'(i_dir_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en1) begin
            r1_v <= i_in_valid && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_c.act    <= i_action;
            r1_c.lface  <= i_load_face;
            r1_c.laddr  <= i_load_address;
            r1_c.lcolor <= i_load_color;
            r1_c.row    <= i_pixel_row;
            r1_c.col    <= i_column;
            r1_c.face   <= w_face;
            r1_side     <= i_hit_side;
            r1_pp       <= 27'(w_hm1) * 27'(r_view_pitch);
            r1_we       <= 32'($signed({1'b0, i_wall_span})) * 32'(r_eye_offset);
            r1_hp       <= w_hprod[29:0];
            r1_ws       <= i_wall_span;
        end
    end

    // ---------------- stage 2: span centre, hit fraction ----------------
    t_carry               r2_c;
    logic signed [BW-1:0] r2_base;
    logic [29:0]          r2_frac;
    logic [15:0]          r2_ws;
    logic [23:0]          w_pos;
    logic signed [BW-1:0] w_base;

    assign w_pos  = (r1_side == SIDE_VERTICAL) ? r_player_y : r_player_x;
    assign w_base = ({{(BW-12){w_hm1[11]}}, w_hm1} <<< 18)
                  + ({{(BW-27){r1_pp[26]}}, r1_pp} <<< 4)
                  + ({{(BW-32){r1_we[31]}}, r1_we} <<< 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_c    <= r1_c;
            r2_base <= w_base;
            r2_frac <= r1_hp + {w_pos[15:0], 14'b0};
            r2_ws   <= r1_ws;
        end
    end

    // ---------------- stage 3: span edges, texture column ----------------
    t_carry               r3_c;
    logic signed [UW-1:0] r3_up, r3_down;
    logic [CW-1:0]        r3_tcol;
    logic signed [BW-1:0] w_half, w_up_raw, w_dn_raw, w_up_adj, w_dn_adj;
    logic [PW-1:0]        w_tprod;

    // Divide by 2^19 with truncation toward zero
    assign w_half   = $signed({{(BW-30){1'b0}}, r2_ws, 14'b0});
    assign w_up_raw = r2_base - w_half;
    assign w_dn_raw = r2_base + w_half;
    assign w_up_adj = $signed(w_up_raw + (w_up_raw[BW-1] ? TRUNC_BIAS : '0)) >>> 19;
    assign w_dn_adj = $signed(w_dn_raw + (w_dn_raw[BW-1] ? TRUNC_BIAS : '0)) >>> 19;
    assign w_tprod  = PW'(r2_frac) * PW'(TEX_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_c    <= r2_c;
            r3_up   <= w_up_adj[UW-1:0];
            r3_down <= w_dn_adj[UW-1:0];
            r3_tcol <= w_tprod[30 +: CW];
        end
    end

    // ---------------- stage 4: region, dividend, divisor ----------------
    typedef struct packed {
        t_carry        c;
        logic [CW-1:0] tcol;
        t_region       region;
    } t_side;

    t_side                r4_s;
    logic [NW-1:0]        r4_num;
    logic [DW-1:0]        r4_den;
    logic signed [UW-1:0] w_row;
    logic signed [UW-1:0] w_roff, w_len;
    t_region              w_region;

    assign w_row  = $signed({{(UW-10){1'b0}}, r3_c.row});
    assign w_roff = w_row - r3_up;
    assign w_len  = r3_down - r3_up;

    always_comb begin
        if (w_row < r3_up && w_row < r3_down) begin
            w_region = REGION_CEILING;
        end else if (w_row < r3_down) begin
            w_region = REGION_WALL;
        end else begin
            w_region = REGION_FLOOR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en4) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_s.c      <= r3_c;
            r4_s.tcol   <= r3_tcol;
            r4_s.region <= w_region;
            r4_num      <= NW'(w_roff[DW-1:0]) * NW'(TEX_HEIGHT);
            r4_den      <= w_len[DW-1:0];
        end
    end

    // ---------------- texture row divider ----------------
    t_side         w_dv_s;
    logic [QW-1:0] w_quot;

    rcts_div #(
        .DW (DW),
        .QW (QW),
        .SW ($bits(t_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .o_ready (w_div_ready),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_side  (r4_s),
        .o_valid (w_div_valid),
        .i_ready (w_ena),
        .o_quot  (w_quot),
        .o_side  (w_dv_s)
    );

    // ---------------- address stage ----------------
    logic          ra_load;
    logic [13:0]   ra_addr;
    logic [31:0]   ra_color;
    logic [9:0]    ra_row;
    logic [10:0]   ra_col;
    t_region       ra_region;
    logic [AW-1:0] w_taddr;

    assign w_taddr = AW'(w_quot) * AW'(TEX_WIDTH) + AW'(w_dv_s.tcol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v <= 1'b0;
        end else if (w_ena) begin
            ra_v <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ena) begin
            ra_load   <= (w_dv_s.c.act == ACT_LOAD);
            ra_addr   <= (w_dv_s.c.act == ACT_LOAD) ?
                         {w_dv_s.c.lface, w_dv_s.c.laddr} :
                         {w_dv_s.c.face, w_taddr[11:0]};
            ra_color  <= w_dv_s.c.lcolor;
            ra_row    <= w_dv_s.c.row;
            ra_col    <= w_dv_s.c.col;
            ra_region <= w_dv_s.region;
        end
    end

    // ---------------- texture store ----------------
    logic [31:0] r_tex [4 * 4096];
    logic [31:0] rm_rdata;
    logic [9:0]  rm_row;
    logic [10:0] rm_col;
    t_region     rm_region;

    // Loads write here and shades read here, so program order holds
    always_ff @(posedge i_clk) begin
        if (w_enm && ra_v) begin
            if (ra_load) begin
                r_tex[ra_addr] <= ra_color;
            end else begin
                rm_rdata <= r_tex[ra_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_v <= 1'b0;
        end else if (w_enm) begin
            rm_v <= ra_v && !ra_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enm) begin
            rm_row    <= ra_row;
            rm_col    <= ra_col;
            rm_region <= ra_region;
        end
    end

    // ---------------- output register ----------------
    logic [9:0]  ro_row;
    logic [10:0] ro_col;
    logic [31:0] ro_color;
    t_region     ro_region;
    logic [31:0] w_color;

    always_comb begin
        case (rm_region)
            REGION_CEILING: w_color = r_ceiling_color;
            REGION_WALL:    w_color = rm_rdata;
            default:        w_color = r_floor_color;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ro_v <= 1'b0;
        end else if (w_eno) begin
            ro_v <= rm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eno) begin
            ro_row    <= rm_row;
            ro_col    <= rm_col;
            ro_color  <= w_color;
            ro_region <= rm_region;
        end
    end

    assign o_out_valid  = ro_v;
    assign o_out_column = ro_col;
    assign o_out_row    = ro_row;
    assign o_out_color  = ro_color;
    assign o_region     = ro_region;

endmodule

>>> hw/rtl/rcts_div.sv
module rcts_div
    import rcts_pkg::*;
#(
    parameter int DW = 17,
    parameter int QW = 6,
    parameter int SW = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [DW+QW-1:0]   i_num,
    input  logic [DW-1:0]      i_den,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [QW-1:0]      o_quot,
    output logic [SW-1:0]      o_side
);

    localparam int NW = DW + QW;

    logic          r_v   [QW];
    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW];
    logic [SW-1:0] r_sd  [QW];

    logic          w_v_in   [QW];
    logic [NW-1:0] w_rem_in [QW];
    logic [DW-1:0] w_den_in [QW];
    logic [QW-1:0] w_q_in   [QW];
    logic [SW-1:0] w_sd_in  [QW];
    logic [NW-1:0] w_sh     [QW];
    logic          w_ge     [QW];
    logic [QW:0]   w_en;

    // One quotient bit per stage, most significant first
    always_comb begin
        w_en[QW] = i_ready;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                w_v_in[k]   = i_valid;
                w_rem_in[k] = i_num;
                w_den_in[k] = i_den;
                w_q_in[k]   = '0;
                w_sd_in[k]  = i_side;
            end else begin
                w_v_in[k]   = r_v[k-1];
                w_rem_in[k] = r_rem[k-1];
                w_den_in[k] = r_den[k-1];
                w_q_in[k]   = r_q[k-1];
                w_sd_in[k]  = r_sd[k-1];
            end
            w_sh[k] = NW'(w_den_in[k]) << (QW - 1 - k);
            w_ge[k] = w_rem_in[k] >= w_sh[k];
        end
        for (int k = QW - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_v_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            if (w_en[k]) begin
                r_rem[k] <= w_ge[k] ? w_rem_in[k] - w_sh[k] : w_rem_in[k];
                r_den[k] <= w_den_in[k];
                r_q[k]   <= w_q_in[k] | (w_ge[k] ? (QW'(1) << (QW - 1 - k)) : '0);
                r_sd[k]  <= w_sd_in[k];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_side  = r_sd[QW-1];

endmodule

>>> tb/sv/raycast_column_texel_shader_tb.sv
module raycast_column_texel_shader_tb;
    import rcts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEX_W      = 64;
    localparam int TEX_H      = 64;
    localparam int FACE_WORDS = 4096;
    // The pipeline holds 7 + clog2(TEX_H) stages; allow some margin on top
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 320;
    localparam int PRELOAD_ITEMS = 200;
    // One past the last register: the block must ignore it
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic        action;
        logic [1:0]  load_face;
        logic [11:0] load_address;
        logic [31:0] load_color;
        logic [9:0]  pixel_row;
        logic [10:0] column;
        logic        hit_side;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [31:0] hit_distance;
        logic [15:0] wall_span;
    } t_item;

    typedef struct {
        logic [10:0] column;
        logic [9:0]  row;
        logic [31:0] color;
        t_region     region;
    } t_pixel;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_item       drv = '{default: '0};
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [10:0] out_column;
    logic [9:0]  out_row;
    logic [31:0] out_color;
    logic [1:0]  out_region;

    // Shadow copy of the block's registers and texture store
    logic [10:0] m_height = SCREEN_HEIGHT_RESET;
    logic [31:0] m_ceiling = '0;
    logic [31:0] m_floor = '0;
    logic [14:0] m_pitch = '0;
    logic [14:0] m_eye = '0;
    logic [23:0] m_player_x = '0;
    logic [23:0] m_player_y = '0;
    logic [31:0] m_texels [FACE_WORDS*4];
    bit          m_loaded [FACE_WORDS*4];

    t_pixel pending_pixels [$];
    int     mismatches = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     quiet_cycles = 0;

    raycast_column_texel_shader u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_action       (drv.action),
        .i_load_face    (drv.load_face),
        .i_load_address (drv.load_address),
        .i_load_color   (drv.load_color),
        .i_pixel_row    (drv.pixel_row),
        .i_column       (drv.column),
        .i_hit_side     (drv.hit_side),
        .i_dir_x        (drv.dir_x),
        .i_dir_y        (drv.dir_y),
        .i_hit_distance (drv.hit_distance),
        .i_wall_span    (drv.wall_span),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_out_column   (out_column),
        .o_out_row      (out_row),
        .o_out_color    (out_color),
        .o_region       (out_region)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Work out the pixel that a shade item produces; false when the row
    // lies at or past the last screen row and nothing comes out. tex_idx
    // gives the store entry of a wall lookup, -1 otherwise.
    function automatic bit shade_pixel(input t_item it, output t_pixel px,
                                       output int tex_idx);
        longint hm1, ws, row, base, up, down, t, pos;
        longint unsigned frac, tcol, trow, addr;
        logic [1:0] face;
        tex_idx = -1;
        hm1  = longint'(m_height) - 1;
        ws   = longint'(it.wall_span);
        row  = longint'(it.pixel_row);
        px.column = it.column;
        px.row    = it.pixel_row;
        if (row >= hm1) return 1'b0;
        base = hm1 * 262144 + hm1 * longint'($signed(m_pitch)) * 16
             + ws * longint'($signed(m_eye)) * 2;
        up   = (base - ws * 16384) / 524288;
        down = (base + ws * 16384) / 524288;
        if (row < up && row < down) begin
            px.color  = m_ceiling;
            px.region = REGION_CEILING;
        end else if (row < down) begin
            // Face from the hit side and direction sign, then the fractional
            // hit position along the wall picks the texture column
            if (it.hit_side == SIDE_VERTICAL) begin
                face = ($signed(it.dir_x) > 0) ? FACE_EAST : FACE_WEST;
                pos  = longint'(m_player_y);
                t    = longint'(it.hit_distance) * longint'($signed(it.dir_y));
            end else begin
                face = ($signed(it.dir_y) > 0) ? FACE_SOUTH : FACE_NORTH;
                pos  = longint'(m_player_x);
                t    = longint'(it.hit_distance) * longint'($signed(it.dir_x));
            end
            t    = pos * 16384 + t;
            frac = longint'(t) & 64'h3FFF_FFFF;
            tcol = (frac * TEX_W) >> 30;
            trow = longint'(row - up) * TEX_H / longint'(down - up);
            addr = (trow * TEX_W + tcol) & 64'hFFF;
            tex_idx   = int'(face) * FACE_WORDS + int'(addr);
            px.color  = m_texels[tex_idx];
            px.region = REGION_WALL;
        end else begin
            px.color  = m_floor;
            px.region = REGION_FLOOR;
        end
        return 1'b1;
    endfunction

    function automatic t_item load_item(input logic [1:0] face, input logic [11:0] addr,
                                        input logic [31:0] color);
        t_item it;
        it = '{default: '0};
        it.action       = ACT_LOAD;
        it.load_face    = face;
        it.load_address = addr;
        it.load_color   = color;
        // Shade fields carry noise; the block must ignore them on a load
        it.pixel_row    = 10'($urandom());
        it.dir_x        = 16'($urandom());
        it.wall_span    = 16'($urandom());
        return it;
    endfunction

    // Present one item, hold it until taken, then advance the shadow state.
    // A wall lookup of a texel never loaded gets a load of that texel first.
    task automatic send_item(input t_item it);
        t_pixel px;
        int     tex_idx;
        if (it.action == ACT_SHADE && shade_pixel(it, px, tex_idx) && tex_idx >= 0 &&
            !m_loaded[tex_idx])
            send_item(load_item(2'(tex_idx / FACE_WORDS), 12'(tex_idx % FACE_WORDS),
                                $urandom()));
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        drv      <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (it.action == ACT_LOAD) begin
            tex_idx = int'(it.load_face) * FACE_WORDS + int'(it.load_address);
            m_texels[tex_idx] = it.load_color;
            m_loaded[tex_idx] = 1'b1;
        end else if (shade_pixel(it, px, tex_idx)) begin
            pending_pixels.push_back(px);
        end
    endtask

    // Drop valid and let the pipeline empty, load items included.
    task automatic drain;
        in_valid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write every register in one burst; the block must be idle.
    task automatic write_registers(input logic [10:0] height, input logic [31:0] ceil_c,
                                   input logic [31:0] floor_c, input logic [14:0] pitch,
                                   input logic [14:0] eye, input logic [23:0] px_x,
                                   input logic [23:0] px_y);
        logic [2:0]  idx [7];
        logic [31:0] val [7];
        idx = '{CFG_SCREEN_HEIGHT, CFG_CEILING_COLOR, CFG_FLOOR_COLOR, CFG_VIEW_PITCH,
                CFG_EYE_OFFSET, CFG_PLAYER_X, CFG_PLAYER_Y};
        val = '{32'(height), ceil_c, floor_c, 32'(pitch), 32'(eye), 32'(px_x), 32'(px_y)};
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        // The unused index must leave every register alone
        cfg_index <= CFG_UNUSED;
        cfg_data  <= $urandom();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        m_height = height; m_ceiling = ceil_c; m_floor = floor_c;
        m_pitch = pitch; m_eye = eye; m_player_x = px_x; m_player_y = px_y;
    endtask

    function automatic t_item shade_item(input logic [9:0] row, input logic side,
                                         input logic [15:0] dx, input logic [15:0] dy,
                                         input logic [31:0] hit_dist,
                                         input logic [15:0] span);
        t_item it;
        it = '{default: '0};
        it.action       = ACT_SHADE;
        it.load_face    = 2'($urandom());
        it.load_address = 12'($urandom());
        it.load_color   = $urandom();
        it.pixel_row    = row;
        it.column       = 11'($urandom());
        it.hit_side     = side;
        it.dir_x        = dx;
        it.dir_y        = dy;
        it.hit_distance = hit_dist;
        it.wall_span    = span;
        return it;
    endfunction

    // Preload a scattered set of texels; the rest are loaded on first use
    task automatic test_texture_fill;
        for (int n = 0; n < PRELOAD_ITEMS; n++)
            send_item(load_item(2'($urandom()), 12'($urandom()), $urandom()));
        drain();
    endtask

    task automatic test_directed;
        t_item it;
        write_registers(11'd480, 32'hC0FF_EE01, 32'hF100_0A02, 15'd0, 15'd0,
                        24'h12_3456, 24'h65_4321);
        // Wall at mid-screen for each face, sign of zero direction included
        send_item(shade_item(10'd239, 1'b0, 16'h0001, 16'h4000, 32'h0003_8000, 16'd3200));
        send_item(shade_item(10'd239, 1'b0, 16'h0000, 16'h8000, 32'h0001_0000, 16'd3200));
        send_item(shade_item(10'd239, 1'b1, 16'h7FFF, 16'h0001, 32'hFFFF_FFFF, 16'd3200));
        send_item(shade_item(10'd239, 1'b1, 16'h8000, 16'h0000, 32'h0000_0000, 16'd3200));
        // Top and bottom of the span, ceiling and floor rows
        send_item(shade_item(10'd139, 1'b1, 16'h1234, 16'hC000, 32'h0002_0000, 16'd3200));
        send_item(shade_item(10'd338, 1'b0, 16'hF000, 16'h7FFF, 32'h0002_0000, 16'd3200));
        send_item(shade_item(10'd0,   1'b0, 16'h4000, 16'h4000, 32'h0001_0000, 16'd3200));
        send_item(shade_item(10'd478, 1'b0, 16'h4000, 16'h4000, 32'h0001_0000, 16'd3200));
        // Last screen row and beyond: nothing comes out
        send_item(shade_item(10'd479, 1'b0, 16'h4000, 16'h4000, 32'h0001_0000, 16'd3200));
        send_item(shade_item(10'd1023, 1'b1, 16'h4000, 16'h4000, 32'h0001_0000, 16'd3200));
        // Empty span and the widest span
        send_item(shade_item(10'd239, 1'b1, 16'h4000, 16'h4000, 32'h0001_0000, 16'd0));
        send_item(shade_item(10'd240, 1'b1, 16'h4000, 16'h4000, 32'h0001_0000, 16'hFFFF));
        send_item(load_item(FACE_EAST, 12'hFFF, 32'hFFFF_FFFF));
        send_item(load_item(FACE_NORTH, 12'h000, 32'h0000_0000));
        drain();
        // Extreme registers: tiny screen, pitch and eye at both ends
        write_registers(11'd2, 32'hFFFF_FFFF, 32'h0000_0000, 15'h4000, 15'h3FFF,
                        24'hFF_FFFF, 24'h00_0000);
        send_item(shade_item(10'd0, 1'b0, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(shade_item(10'd0, 1'b1, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 16'd16));
        send_item(shade_item(10'd1, 1'b1, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 16'd16));
        drain();
        write_registers(11'd1024, 32'h0000_0000, 32'hFFFF_FFFF, 15'h3FFF, 15'h4000,
                        24'h00_0000, 24'hFF_FFFF);
        send_item(shade_item(10'd1022, 1'b0, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(shade_item(10'd0, 1'b1, 16'h7FFF, 16'h8000, 32'h8000_0000, 16'hFFFF));
        send_item(shade_item(10'd512, 1'b0, 16'hFFFF, 16'h0001, 32'h0000_0001, 16'd8));
        drain();
    endtask

    // One random phase: fresh registers, then mostly on-screen shade items
    task automatic test_random_phase(input int sel);
        logic [10:0] height;
        logic [14:0] pitch, eye;
        logic [9:0]  row;
        logic [15:0] span;
        t_item       it;
        case (sel)
            0: height = 11'd2;
            1: height = 11'd1024;
            default: height = 11'($urandom_range(2, 1024));
        endcase
        pitch = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 1) ? 16383 : -16384)
                                            : 15'($urandom_range(0, 4095) - 2048);
        eye   = ($urandom_range(0, 3) == 0) ? 15'($urandom())
                                            : 15'($urandom_range(0, 8191) - 4096);
        write_registers(height, $urandom(), $urandom(), pitch, eye,
                        24'($urandom()), 24'($urandom()));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(load_item(2'($urandom()), 12'($urandom()), $urandom()));
            end else begin
                row  = ($urandom_range(0, 3) == 0) ? 10'($urandom())
                                                   : 10'($urandom_range(0, int'(height) - 2));
                span = ($urandom_range(0, 2) == 0) ? 16'($urandom())
                                                   : 16'($urandom_range(0, int'(height) * 32));
                it = shade_item(row, 1'($urandom()), 16'($urandom()), 16'($urandom()),
                                $urandom(), span);
                send_item(it);
            end
        end
        drain();
    endtask

    // Result checker and receiver stall pattern
    always @(posedge clk) begin
        t_pixel want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel col %0d row %0d", out_column, out_row);
                end else begin
                    want = pending_pixels.pop_front();
                    if (out_column !== want.column || out_row !== want.row ||
                        out_color !== want.color || out_region !== want.region) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"pixel mismatch: exp col %0d row %0d color %h ",
                                      "region %0d, got col %0d row %0d color %h region %0d"},
                                     want.column, want.row, want.color, want.region,
                                     out_column, out_row, out_color, out_region);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 22;
        recv_idle_pct = 80;
        test_texture_fill();
        test_directed();
        test_random_phase(0);
        send_idle_pct = 80;
        recv_idle_pct = 22;
        test_random_phase(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(2);
        test_random_phase(3);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
